FILE: design/ssw_pkg.sv
// Shared types, constants and helpers for the split stopwatch.
// Used by the channel interfaces, the input stage, the core and the top level.
package ssw_pkg;

  localparam int unsigned OpW   = 3;
  localparam int unsigned PrioW = 2;
  localparam int unsigned TimeW = 32;

  localparam int unsigned PauseLevelsDefault = 3;

  typedef enum logic [OpW-1:0] {
    OP_RESET        = 3'd0,
    OP_UPDATE       = 3'd1,
    OP_PAUSE        = 3'd2,
    OP_UNPAUSE      = 3'd3,
    OP_STORE        = 3'd4,
    OP_LEVEL_FINISH = 3'd5,
    OP_RUN_FINISH   = 3'd6
  } op_e;

  typedef logic [TimeW-1:0] time_t;

  typedef struct packed {
    logic [OpW-1:0]   operation;
    logic [PrioW-1:0] priority_req;
    time_t            timestamp_ms;
  } item_t;

  typedef struct packed {
    time_t total_time;
    time_t level_time;
    logic  paused;
    logic  run_finished;
    logic  level_differs;
  } result_t;

  // Add, clamping at all ones on carry out.
  function automatic time_t sat_add(time_t a, time_t b);
    logic [TimeW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TimeW] ? '1 : sum[TimeW-1:0];
  endfunction

endpackage

FILE: design/ssw_in_if.sv
// Input channel: valid/ready handshake with one stopwatch event.
// Depends on ssw_pkg for field widths.
interface ssw_in_if;
  logic                       valid;
  logic                       ready;
  logic [ssw_pkg::OpW-1:0]    operation;
  logic [ssw_pkg::PrioW-1:0]  priority_req;
  logic [ssw_pkg::TimeW-1:0]  timestamp_ms;

  modport source (output valid, operation, priority_req, timestamp_ms, input ready);
  modport sink   (input valid, operation, priority_req, timestamp_ms, output ready);
endinterface

FILE: design/ssw_out_if.sv
// Output channel: valid/ready handshake with one stopwatch result.
// Depends on ssw_pkg for field widths.
interface ssw_out_if;
  logic                       valid;
  logic                       ready;
  logic [ssw_pkg::TimeW-1:0]  total_time;
  logic [ssw_pkg::TimeW-1:0]  level_time;
  logic                       paused;
  logic                       run_finished;
  logic                       level_differs;

  modport source (output valid, total_time, level_time, paused, run_finished,
                  level_differs, input ready);
  modport sink   (input valid, total_time, level_time, paused, run_finished,
                  level_differs, output ready);
endinterface

FILE: design/ssw_in_stage.sv
// Input register for stopwatch events, one entry deep with pass-through ready.
// Depends on ssw_pkg for the event type.
module ssw_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ssw_pkg::item_t in_item_i,
  output logic           item_valid_o,
  output ssw_pkg::item_t item_o,
  input  logic           item_ready_i
);
  import ssw_pkg::*;

  logic  valid_q;
  item_t item_q;

  assign in_ready_o   = !valid_q || item_ready_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

endmodule

FILE: design/ssw_core.sv
// Stopwatch state, event evaluation and result register.
// Depends on ssw_pkg for the operation codes, types and saturating add.
module ssw_core #(
  parameter int unsigned PAUSE_LEVELS = ssw_pkg::PauseLevelsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  input  ssw_pkg::item_t   item_i,
  output logic             item_ready_o,
  output logic             res_valid_o,
  output ssw_pkg::result_t res_o,
  input  logic             res_ready_i
);
  import ssw_pkg::*;

  logic [PAUSE_LEVELS-1:0] flags_q, flags_d, prio_mask;
  time_t last_q, last_d;
  time_t st_tot_q, st_tot_d, st_lvl_q, st_lvl_d;
  time_t sh_tot_q, sh_tot_d, sh_lvl_q, sh_lvl_d;
  logic  fin_q, fin_d;
  logic  differs;
  logic  res_valid_q;
  result_t res_q;

  time_t elapsed, acc_tot, acc_lvl;
  logic  running, prio_ok, take;

  assign item_ready_o = !res_valid_q || res_ready_i;
  assign take         = item_valid_i && item_ready_o;

  assign running = ~|flags_q;
  assign prio_ok = 32'(item_i.priority_req) < PAUSE_LEVELS;
  assign elapsed = item_i.timestamp_ms - last_q;
  assign acc_tot = sat_add(st_tot_q, elapsed);
  assign acc_lvl = sat_add(st_lvl_q, elapsed);

  // Flags at the requested priority and every lower one.
  always_comb begin
    for (int i = 0; i < PAUSE_LEVELS; i++) begin
      prio_mask[i] = 32'(i) >= 32'(item_i.priority_req);
    end
  end

  always_comb begin
    flags_d  = flags_q;
    last_d   = last_q;
    st_tot_d = st_tot_q;
    st_lvl_d = st_lvl_q;
    sh_tot_d = sh_tot_q;
    sh_lvl_d = sh_lvl_q;
    fin_d    = fin_q;
    differs  = 1'b0;
    case (op_e'(item_i.operation))
      OP_RESET: begin
        flags_d  = '1;
        last_d   = '0;
        st_tot_d = '0;
        st_lvl_d = '0;
        sh_tot_d = '0;
        sh_lvl_d = '0;
        fin_d    = 1'b0;
      end
      OP_UPDATE: begin
        if (running) begin
          sh_tot_d = acc_tot;
          sh_lvl_d = acc_lvl;
        end
      end
      OP_PAUSE: begin
        if (prio_ok) begin
          if (running) begin
            st_tot_d = acc_tot;
            st_lvl_d = acc_lvl;
            sh_tot_d = acc_tot;
            sh_lvl_d = acc_lvl;
            last_d   = item_i.timestamp_ms;
          end
          flags_d = flags_q | prio_mask;
        end
      end
      OP_UNPAUSE: begin
        if (prio_ok) begin
          flags_d = flags_q & ~prio_mask;
          // Restart the interval when the last flag drops.
          if (!running && ~|(flags_q & ~prio_mask)) begin
            last_d = item_i.timestamp_ms;
          end
        end
      end
      OP_STORE: begin
        st_tot_d = acc_tot;
        st_lvl_d = acc_lvl;
        sh_tot_d = acc_tot;
        sh_lvl_d = acc_lvl;
        last_d   = item_i.timestamp_ms;
      end
      OP_LEVEL_FINISH, OP_RUN_FINISH: begin
        if (!(op_e'(item_i.operation) == OP_RUN_FINISH && fin_q)) begin
          if (running) begin
            st_tot_d = acc_tot;
            sh_tot_d = acc_tot;
            sh_lvl_d = acc_lvl;
            last_d   = item_i.timestamp_ms;
            differs  = acc_lvl != acc_tot;
          end else begin
            differs  = sh_lvl_q != sh_tot_q;
          end
          st_lvl_d = '0;
          if (op_e'(item_i.operation) == OP_RUN_FINISH) begin
            flags_d = '1;
            fin_d   = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '1;
      last_q      <= '0;
      st_tot_q    <= '0;
      st_lvl_q    <= '0;
      sh_tot_q    <= '0;
      sh_lvl_q    <= '0;
      fin_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (take) begin
        flags_q  <= flags_d;
        last_q   <= last_d;
        st_tot_q <= st_tot_d;
        st_lvl_q <= st_lvl_d;
        sh_tot_q <= sh_tot_d;
        sh_lvl_q <= sh_lvl_d;
        fin_q    <= fin_d;
      end
      if (item_ready_o) begin
        res_valid_q <= item_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q.total_time    <= sh_tot_d;
      res_q.level_time    <= sh_lvl_d;
      res_q.paused        <= |flags_d;
      res_q.run_finished  <= fin_d;
      res_q.level_differs <= differs;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

FILE: design/split_stopwatch_priority_pause.sv
// Split stopwatch with prioritized pause: top level.
// Path: an accepted event passes the input register, then the result register, before its
// result is presented on the output channel.
// Throughput: one event per cycle unless the output channel holds results back.
// Reset: all pause flags set, accumulators, shown times and stamp zero, run not finished.
// Depends on ssw_pkg, ssw_in_if, ssw_out_if, ssw_in_stage and ssw_core.
module split_stopwatch_priority_pause #(
  parameter int unsigned PAUSE_LEVELS = ssw_pkg::PauseLevelsDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ssw_in_if.sink   in_i,
  ssw_out_if.source out_o
);
  import ssw_pkg::*;

  item_t   in_item, item;
  logic    item_valid, item_ready;
  result_t res;

  assign in_item.operation    = in_i.operation;
  assign in_item.priority_req = in_i.priority_req;
  assign in_item.timestamp_ms = in_i.timestamp_ms;

  ssw_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_ready_i (item_ready)
  );

  ssw_core #(
    .PAUSE_LEVELS (PAUSE_LEVELS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_ready_o (item_ready),
    .res_valid_o  (out_o.valid),
    .res_o        (res),
    .res_ready_i  (out_o.ready)
  );

  assign out_o.total_time    = res.total_time;
  assign out_o.level_time    = res.level_time;
  assign out_o.paused        = res.paused;
  assign out_o.run_finished  = res.run_finished;
  assign out_o.level_differs = res.level_differs;

endmodule

FILE: bench/split_stopwatch_priority_pause_tb.sv
// Self-checking bench for the split stopwatch: drives stopwatch events through the
// input channel and checks each result against an in-bench model of the stopwatch.
// Depends on ssw_pkg, ssw_in_if, ssw_out_if and the split_stopwatch_priority_pause RTL.
module split_stopwatch_priority_pause_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssw_pkg::*;

  localparam int unsigned PauseLevels = PauseLevelsDefault;
  localparam logic [OpW-1:0] OpUnused = 3'd7;
  localparam logic [PrioW-1:0] PrioBeyond = 2'd3;
  localparam int unsigned RandomEvents = 1350;
  localparam int unsigned CalmTail = 150;

  logic clk_i;
  logic rst_ni;

  ssw_in_if in_if ();
  ssw_out_if out_if ();

  split_stopwatch_priority_pause dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  item_t pending_events[$];
  result_t expected_readings[$];
  int unsigned errors = 0;
  bit in_taken = 0;
  bit idle_on = 0;
  int unsigned src_gap = 0;
  int unsigned snk_gap = 0;
  time_t clock_ms = 0;

  // Stopwatch model state
  time_t sw_last;
  time_t sw_run_acc;
  time_t sw_lvl_acc;
  time_t sw_run_shown;
  time_t sw_lvl_shown;
  logic [PauseLevels-1:0] sw_holds;
  logic sw_done;

  function automatic time_t clamp_sum(time_t a, time_t b);
    time_t s;
    s = a + b;
    return (s < a) ? '1 : s;
  endfunction

  function automatic logic [PauseLevels-1:0] levels_from(logic [PrioW-1:0] p);
    logic [PauseLevels-1:0] m;
    for (int i = 0; i < PauseLevels; i++) m[i] = (i >= p);
    return m;
  endfunction

  function automatic void clear_watch();
    sw_last = '0;
    sw_run_acc = '0;
    sw_lvl_acc = '0;
    sw_run_shown = '0;
    sw_lvl_shown = '0;
    sw_holds = '1;
    sw_done = 1'b0;
  endfunction

  // Fold the interval since the last stamp into both accumulators.
  function automatic void bank_interval(time_t ts);
    time_t gap;
    gap = ts - sw_last;
    sw_run_acc = clamp_sum(sw_run_acc, gap);
    sw_lvl_acc = clamp_sum(sw_lvl_acc, gap);
    sw_run_shown = sw_run_acc;
    sw_lvl_shown = sw_lvl_acc;
    sw_last = ts;
  endfunction

  function automatic void hold_from(logic [PrioW-1:0] p, time_t ts);
    if (sw_holds == '0) bank_interval(ts);
    sw_holds |= levels_from(p);
  endfunction

  function automatic logic close_level(time_t ts);
    logic differs;
    if (sw_holds == '0) bank_interval(ts);
    differs = (sw_lvl_shown != sw_run_shown);
    sw_lvl_acc = '0;
    return differs;
  endfunction

  function automatic result_t advance_watch(item_t ev);
    result_t r;
    logic differs;
    logic was_held;
    logic prio_ok;
    time_t gap;
    differs = 1'b0;
    prio_ok = (ev.priority_req < PauseLevels);
    gap = ev.timestamp_ms - sw_last;
    case (ev.operation)
      OP_RESET: clear_watch();
      OP_UPDATE: begin
        if (sw_holds == '0) begin
          sw_run_shown = clamp_sum(sw_run_acc, gap);
          sw_lvl_shown = clamp_sum(sw_lvl_acc, gap);
        end
      end
      OP_PAUSE: begin
        if (prio_ok) hold_from(ev.priority_req, ev.timestamp_ms);
      end
      OP_UNPAUSE: begin
        if (prio_ok) begin
          was_held = |sw_holds;
          sw_holds &= ~levels_from(ev.priority_req);
          // restart the interval only on the transition into running
          if (was_held && sw_holds == '0) sw_last = ev.timestamp_ms;
        end
      end
      OP_STORE: bank_interval(ev.timestamp_ms);
      OP_LEVEL_FINISH: differs = close_level(ev.timestamp_ms);
      OP_RUN_FINISH: begin
        if (!sw_done) begin
          hold_from('0, ev.timestamp_ms);
          differs = close_level(ev.timestamp_ms);
          sw_done = 1'b1;
        end
      end
      default: ;
    endcase
    r.total_time = sw_run_shown;
    r.level_time = sw_lvl_shown;
    r.paused = |sw_holds;
    r.run_finished = sw_done;
    r.level_differs = differs;
    return r;
  endfunction

  task automatic queue_event(logic [OpW-1:0] op, logic [PrioW-1:0] prio, time_t ts);
    item_t ev;
    ev.operation = op;
    ev.priority_req = prio;
    ev.timestamp_ms = ts;
    pending_events.push_back(ev);
  endtask

  task automatic tick_clock();
    if ($urandom_range(0, 11) == 0) clock_ms += $urandom;
    else clock_ms += $urandom_range(0, 2000);
  endtask

  // A plausible run: optional reset, start, a mix of events, usually a run finish.
  task automatic play_session();
    int unsigned steps;
    int unsigned pick;
    logic [PrioW-1:0] prio;
    clock_ms = ($urandom_range(0, 3) == 0) ? (32'hFFFF_FFFF - $urandom_range(0, 50000))
                                            : $urandom;
    if ($urandom_range(0, 1) == 0)
      queue_event(OP_RESET, PrioW'($urandom_range(0, 3)), clock_ms);
    tick_clock();
    queue_event(OP_UNPAUSE, '0, clock_ms);
    steps = $urandom_range(5, 30);
    repeat (steps) begin
      tick_clock();
      pick = $urandom_range(0, 99);
      prio = ($urandom_range(0, 9) == 0) ? PrioBeyond : PrioW'($urandom_range(0, 2));
      if (pick < 30) queue_event(OP_UPDATE, PrioW'($urandom_range(0, 3)), clock_ms);
      else if (pick < 45) queue_event(OP_STORE, PrioW'($urandom_range(0, 3)), clock_ms);
      else if (pick < 60) queue_event(OP_PAUSE, prio, clock_ms);
      else if (pick < 80) queue_event(OP_UNPAUSE, prio, clock_ms);
      else if (pick < 92)
        queue_event(OP_LEVEL_FINISH, PrioW'($urandom_range(0, 3)), clock_ms);
      else if (pick < 95)
        queue_event(OP_RUN_FINISH, PrioW'($urandom_range(0, 3)), clock_ms);
      else if (pick < 98) queue_event(OpUnused, PrioW'($urandom_range(0, 3)), clock_ms);
      else queue_event(OP_RESET, PrioW'($urandom_range(0, 3)), clock_ms);
    end
    if ($urandom_range(0, 9) < 6) begin
      tick_clock();
      queue_event(OP_RUN_FINISH, PrioW'($urandom_range(0, 3)), clock_ms);
    end
  endtask

  task automatic compare_reading(result_t want);
    if (out_if.total_time !== want.total_time) begin
      errors++;
      $error("total_time: expected %0d, got %0d", want.total_time, out_if.total_time);
    end
    if (out_if.level_time !== want.level_time) begin
      errors++;
      $error("level_time: expected %0d, got %0d", want.level_time, out_if.level_time);
    end
    if (out_if.paused !== want.paused) begin
      errors++;
      $error("paused: expected %0b, got %0b", want.paused, out_if.paused);
    end
    if (out_if.run_finished !== want.run_finished) begin
      errors++;
      $error("run_finished: expected %0b, got %0b", want.run_finished, out_if.run_finished);
    end
    if (out_if.level_differs !== want.level_differs) begin
      errors++;
      $error("level_differs: expected %0b, got %0b", want.level_differs,
             out_if.level_differs);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Monitor: check result transfers, then model each accepted event.
  always @(posedge clk_i) begin
    item_t ev;
    if (!rst_ni) begin
      in_taken = 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_readings.size() == 0) begin
          errors++;
          $error("unexpected result: total_time %0d level_time %0d", out_if.total_time,
                 out_if.level_time);
        end else begin
          compare_reading(expected_readings.pop_front());
        end
      end
      in_taken = in_if.valid && in_if.ready;
      if (in_taken) begin
        ev.operation = in_if.operation;
        ev.priority_req = in_if.priority_req;
        ev.timestamp_ms = in_if.timestamp_ms;
        expected_readings.push_back(advance_watch(ev));
      end
      // alternate stretches with and without idling; none near the end
      idle_on = (pending_events.size() > CalmTail) &&
                ((pending_events.size() / 120) % 3 != 0);
    end
  end

  // Driver: drop the transferred event, then hold, idle or present the next one.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) pending_events.pop_front();
      if (!idle_on) src_gap = 0;
      if (!(in_if.valid && !in_taken)) begin
        if (src_gap > 0) begin
          src_gap--;
          in_if.valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(0, 12);
          in_if.valid <= 1'b0;
        end else if (pending_events.size() > 0) begin
          in_if.valid <= 1'b1;
          in_if.operation <= pending_events[0].operation;
          in_if.priority_req <= pending_events[0].priority_req;
          in_if.timestamp_ms <= pending_events[0].timestamp_ms;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result side back-pressure.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!idle_on) snk_gap = 0;
      if (snk_gap > 0) begin
        snk_gap--;
        out_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        snk_gap = $urandom_range(0, 12);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned target;
    in_if.valid = 1'b0;
    in_if.operation = '0;
    in_if.priority_req = '0;
    in_if.timestamp_ms = '0;
    out_if.ready = 1'b0;
    rst_ni = 1'b0;
    clear_watch();

    // Directed: partial and out-of-range pauses, splits, wrap, saturation, finish.
    queue_event(OP_UPDATE, 2'd0, 32'd100);
    queue_event(OP_UNPAUSE, 2'd2, 32'd200);
    queue_event(OP_UNPAUSE, PrioBeyond, 32'd300);
    queue_event(OP_PAUSE, PrioBeyond, 32'd350);
    queue_event(OP_UNPAUSE, 2'd0, 32'd1000);
    queue_event(OP_UPDATE, 2'd1, 32'd1500);
    queue_event(OP_STORE, 2'd3, 32'd2000);
    queue_event(OP_PAUSE, 2'd1, 32'd2500);
    queue_event(OP_UNPAUSE, 2'd2, 32'd3000);
    queue_event(OP_UNPAUSE, 2'd1, 32'd5000);
    queue_event(OP_LEVEL_FINISH, 2'd0, 32'd6000);
    queue_event(OP_STORE, 2'd0, 32'd7000);
    queue_event(OP_LEVEL_FINISH, 2'd2, 32'd7000);
    queue_event(OpUnused, 2'd3, 32'h8000_0000);
    queue_event(OP_UPDATE, 2'd0, 32'd100);
    queue_event(OP_STORE, 2'd0, 32'hFFFF_FFFF);
    queue_event(OP_STORE, 2'd0, 32'd0);
    queue_event(OP_RUN_FINISH, 2'd0, 32'd5);
    queue_event(OP_RUN_FINISH, 2'd1, 32'd9);
    queue_event(OP_UNPAUSE, 2'd0, 32'd10);
    queue_event(OP_UPDATE, 2'd0, 32'd20);
    queue_event(OP_PAUSE, 2'd2, 32'd40);
    queue_event(OP_STORE, 2'd0, 32'd50);
    queue_event(OP_LEVEL_FINISH, 2'd0, 32'd60);
    queue_event(OP_RESET, 2'd3, 32'hFFFF_FFFF);
    queue_event(OP_RUN_FINISH, 2'd2, 32'd70);

    target = pending_events.size() + RandomEvents;
    while (pending_events.size() < target) begin
      if ($urandom_range(0, 9) < 8) begin
        play_session();
      end else begin
        repeat ($urandom_range(1, 6))
          queue_event(OpW'($urandom_range(0, 7)), PrioW'($urandom_range(0, 3)), $urandom);
      end
    end

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_events.size() != 0 || expected_readings.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: split_stopwatch_priority_pause.f
design/ssw_pkg.sv
design/ssw_in_if.sv
design/ssw_out_if.sv
design/ssw_in_stage.sv
design/ssw_core.sv
design/split_stopwatch_priority_pause.sv
bench/split_stopwatch_priority_pause_tb.sv
